// ===== hw/rtl/dsel_pkg.sv =====
// Shared types and constants for the depth-sorted entry list.
package dsel_pkg;

   localparam int DEF_LIST_DEPTH = 64;
   localparam int DEF_KEY_BITS   = 16;

   localparam int REQ_TYPE_W   = 2;
   localparam int ENTRY_ID_W   = 16;
   localparam int DEPTH_KEY_W  = 16;
   localparam int SLOT_INDEX_W = 6;

   localparam int STATUS_W      = 2;
   localparam int SLOT_NOW_W    = 6;
   localparam int READ_ID_W     = 16;
   localparam int ENTRY_COUNT_W = 7;

   localparam int REQ_FIELDS_W = ENTRY_ID_W + DEPTH_KEY_W + SLOT_INDEX_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = SLOT_NOW_W + READ_ID_W + ENTRY_COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_ADD    = 2'd0,
      REQ_MOVE   = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_READ   = 2'd3
   } dsel_req_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_BAD_SLOT  = 2'd3
   } dsel_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_NBR_L_RD,
      ST_NBR_L_CHK,
      ST_NBR_R_RD,
      ST_NBR_R_CHK,
      ST_MOVE_DECIDE,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_READ_CHK,
      ST_RESP
   } dsel_state_type;

endpackage

// ===== hw/rtl/depth_sorted_entry_list.sv =====
// Depth-sorted entry list: handles kept in ascending key order in one memory.
//
// The block holds up to LIST_DEPTH entry handles ordered by a signed depth key
// and serves one request at a time: add, move, remove or read a slot. Every
// request gives exactly one result item. The entries live in a single-port
// memory with a registered read, and a small sequencer walks it with one shared
// step adder and one key comparator, visiting every entry with an address
// step and then a compare-and-write step. An add walks down from the top to
// the slot that it lands in, a remove or a missed handle walks the whole list
// and a move may walk it twice. The input side is held off from acceptance
// until the result of the current item has been handed to the output
// register, which in turn lets the next item be accepted while that result
// waits.
// There is no clearing pass after reset: entries at or above the count are
// never read.
module depth_sorted_entry_list #(
   parameter int LIST_DEPTH = dsel_pkg::DEF_LIST_DEPTH,
   parameter int KEY_BITS   = dsel_pkg::DEF_KEY_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // entry_id [15:0], depth_key [31:16], slot_index [37:32], zero fill above
   input  logic [dsel_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type [1:0]
   input  logic [dsel_pkg::REQ_TYPE_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // slot_now [5:0], read_id [21:6], entry_count [28:22], zero fill above
   output logic [dsel_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status [1:0]
   output logic [dsel_pkg::STATUS_W-1:0]      rsp_tuser
);
   import dsel_pkg::*;

   localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W  = $clog2(LIST_DEPTH);
   localparam int ENTRY_W = ENTRY_ID_W + KEY_BITS;
   localparam int KF_W    = (KEY_BITS < DEPTH_KEY_W) ? KEY_BITS : DEPTH_KEY_W;
   localparam int IDX_W   = (CNT_W > SLOT_INDEX_W) ? CNT_W : SLOT_INDEX_W;
   localparam int SNW_W   = (CNT_W > SLOT_NOW_W) ? CNT_W : SLOT_NOW_W;
   localparam int ECW_W   = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;
   localparam int PAD_W   = RSP_TDATA_W - RSP_FIELDS_W;

   // Sequencer and datapath registers.
   dsel_state_type          state_ff, state_in;
   dsel_req_type            op_ff, op_in;
   logic [ENTRY_ID_W-1:0]   id_ff, id_in;
   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic [SLOT_INDEX_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    ooo_ff, ooo_in;

   // Result of the item in flight, before it reaches the output register.
   dsel_status_type         res_status_ff, res_status_in;
   logic [CNT_W-1:0]        res_slot_ff, res_slot_in;
   logic [READ_ID_W-1:0]    res_read_ff, res_read_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   dsel_status_type         rsp_status_ff, rsp_status_in;
   logic [SLOT_NOW_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [READ_ID_W-1:0]    rsp_read_ff, rsp_read_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Entry memory: handle in the upper bits, key in the lower bits.
   logic [ENTRY_W-1:0]      entry_mem [LIST_DEPTH];
   logic [ENTRY_W-1:0]      rd_data_ff;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_wa;
   logic [ADDR_W-1:0]       mem_ra;
   logic [ENTRY_W-1:0]      mem_wd;

   // Shared step adder and key comparator.
   logic [CNT_W-1:0]        step_opnd;
   logic                    step_down;
   logic [CNT_W-1:0]        step_res;
   logic signed [KEY_BITS-1:0] rd_key;
   logic [ENTRY_ID_W-1:0]   rd_handle;
   logic                    key_gt;
   logic                    key_lt;

   // Field extraction and width helpers.
   logic signed [KF_W-1:0]  key_trim;
   logic [IDX_W-1:0]        slot_cmp;
   logic [IDX_W-1:0]        cnt_cmp;
   logic [SNW_W-1:0]        slot_wide;
   logic [ECW_W-1:0]        count_wide;
   logic                    req_accept;

   assign req_accept = req_tvalid && req_tready;

   // Only the low bits of the key field take part, sign-extended to the key width.
   assign key_trim = req_tdata[ENTRY_ID_W +: KF_W];

   assign slot_cmp   = IDX_W'(slot_ff);
   assign cnt_cmp    = IDX_W'(cnt_ff);
   assign slot_wide  = SNW_W'(res_slot_ff);
   assign count_wide = ECW_W'(cnt_ff);

   assign step_res  = step_down ? (step_opnd - CNT_W'(1)) : (step_opnd + CNT_W'(1));
   assign rd_key    = rd_data_ff[KEY_BITS-1:0];
   assign rd_handle = rd_data_ff[ENTRY_W-1:KEY_BITS];
   assign key_gt    = key_ff > rd_key;
   assign key_lt    = key_ff < rd_key;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= entry_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      key_ff        <= key_in;
      slot_ff       <= slot_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      ooo_ff        <= ooo_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_read_ff   <= res_read_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      key_in        = key_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      ooo_in        = ooo_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_read_in   = res_read_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_wa        = idx_ff[ADDR_W-1:0];
      mem_wd        = {id_ff, key_ff};
      mem_ra        = idx_ff[ADDR_W-1:0];
      step_opnd     = idx_ff;
      step_down     = 1'b0;
      req_tready    = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in    = dsel_req_type'(req_tuser);
               id_in    = req_tdata[ENTRY_ID_W-1:0];
               key_in   = KEY_BITS'(key_trim);
               slot_in  = req_tdata[ENTRY_ID_W+DEPTH_KEY_W +: SLOT_INDEX_W];
               state_in = ST_START;
            end
         end
         ST_START: begin
            res_status_in = STAT_OK;
            res_slot_in   = '0;
            res_read_in   = '0;
            case (op_ff)
               REQ_ADD: begin
                  if (cnt_ff == CNT_W'(LIST_DEPTH)) begin
                     res_status_in = STAT_FULL;
                     state_in      = ST_RESP;
                  end else begin
                     idx_in   = cnt_ff;
                     state_in = ST_ADD_RD;
                  end
               end
               REQ_MOVE, REQ_REMOVE: begin
                  idx_in   = '0;
                  state_in = ST_FIND_RD;
               end
               REQ_READ: begin
                  if (slot_cmp < cnt_cmp) begin
                     mem_ra   = slot_cmp[ADDR_W-1:0];
                     state_in = ST_READ_CHK;
                  end else begin
                     res_status_in = STAT_BAD_SLOT;
                     state_in      = ST_RESP;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         // Insertion walks down from the top, moving each larger-or-equal entry
         // up by one until a smaller key (or the bottom) marks the new slot.
         ST_ADD_RD: begin
            if (idx_ff == '0) begin
               mem_we      = 1'b1;
               res_slot_in = idx_ff;
               step_opnd   = cnt_ff;
               cnt_in      = step_res;
               state_in    = ST_RESP;
            end else begin
               step_down = 1'b1;
               mem_ra    = step_res[ADDR_W-1:0];
               state_in  = ST_ADD_WR;
            end
         end
         ST_ADD_WR: begin
            mem_we = 1'b1;
            if (key_gt) begin
               res_slot_in = idx_ff;
               step_opnd   = cnt_ff;
               cnt_in      = step_res;
               state_in    = ST_RESP;
            end else begin
               mem_wd    = rd_data_ff;
               step_down = 1'b1;
               idx_in    = step_res;
               state_in  = ST_ADD_RD;
            end
         end
         ST_FIND_RD: begin
            if (idx_ff == cnt_ff) begin
               res_status_in = STAT_NOT_FOUND;
               state_in      = ST_RESP;
            end else begin
               state_in = ST_FIND_CHK;
            end
         end
         ST_FIND_CHK: begin
            if (rd_handle == id_ff) begin
               pos_in = idx_ff;
               if (op_ff == REQ_REMOVE) begin
                  res_slot_in = idx_ff;
                  state_in    = ST_DEL_RD;
               end else begin
                  ooo_in   = 1'b0;
                  state_in = ST_NBR_L_RD;
               end
            end else begin
               idx_in   = step_res;
               state_in = ST_FIND_RD;
            end
         end
         ST_NBR_L_RD: begin
            if (pos_ff == '0) begin
               state_in = ST_NBR_R_RD;
            end else begin
               step_opnd = pos_ff;
               step_down = 1'b1;
               mem_ra    = step_res[ADDR_W-1:0];
               state_in  = ST_NBR_L_CHK;
            end
         end
         ST_NBR_L_CHK: begin
            ooo_in   = key_lt;
            state_in = ST_NBR_R_RD;
         end
         ST_NBR_R_RD: begin
            step_opnd = pos_ff;
            if (step_res == cnt_ff) begin
               state_in = ST_MOVE_DECIDE;
            end else begin
               mem_ra   = step_res[ADDR_W-1:0];
               state_in = ST_NBR_R_CHK;
            end
         end
         ST_NBR_R_CHK: begin
            ooo_in   = ooo_ff || key_gt;
            state_in = ST_MOVE_DECIDE;
         end
         // A key equal to a neighbor still counts as in order.
         ST_MOVE_DECIDE: begin
            if (ooo_ff) begin
               idx_in   = pos_ff;
               state_in = ST_DEL_RD;
            end else begin
               mem_we      = 1'b1;
               mem_wa      = pos_ff[ADDR_W-1:0];
               res_slot_in = pos_ff;
               state_in    = ST_RESP;
            end
         end
         // Take-out closes the gap by pulling every later entry down one slot.
         ST_DEL_RD: begin
            if (step_res == cnt_ff) begin
               // The new count is one below, which equals the current index.
               cnt_in = idx_ff;
               if (op_ff == REQ_MOVE) begin
                  state_in = ST_ADD_RD;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               mem_ra   = step_res[ADDR_W-1:0];
               state_in = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            mem_we   = 1'b1;
            mem_wd   = rd_data_ff;
            idx_in   = step_res;
            state_in = ST_DEL_RD;
         end
         ST_READ_CHK: begin
            res_read_in = rd_handle;
            res_slot_in = slot_cmp[CNT_W-1:0];
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = slot_wide[SLOT_NOW_W-1:0];
               rsp_read_in   = res_read_ff;
               rsp_count_in  = count_wide[ENTRY_COUNT_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_count_ff, rsp_read_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

   // The entry count never exceeds the list depth.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count above list depth");

   // Once an item is taken, the block is not ready in the cycle after it.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("input accepted back to back");

   // A rejected request reports slot zero and no handle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status_ff != STAT_OK) |->
         (rsp_slot_ff == '0 && rsp_read_ff == '0))
      else $error("rejected request carries slot or handle");

   // The list is only written while an item is being worked on.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_RESP) |-> !mem_we)
      else $error("entry memory written outside an item");

endmodule

// ===== tb/dsel_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the depth-sorted entry list: tracks the list and compares every result.
module dsel_result_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [dsel_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [dsel_pkg::REQ_TYPE_W-1:0]    req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [dsel_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic [dsel_pkg::STATUS_W-1:0]      rsp_tuser,
   output int                                 fail_count,
   output int                                 results_checked,
   output int                                 full_rejects,
   output int                                 n_due
);
   import dsel_pkg::*;

   typedef struct packed {
      dsel_status_type            status;
      logic [SLOT_NOW_W-1:0]      slot_now;
      logic [READ_ID_W-1:0]       read_id;
      logic [ENTRY_COUNT_W-1:0]   entry_count;
   } list_result_type;

   // Shadow copy of the list, kept in slot order.
   logic [ENTRY_ID_W-1:0]         held_id  [DEF_LIST_DEPTH];
   logic signed [DEPTH_KEY_W-1:0] held_key [DEF_LIST_DEPTH];
   int                            held_n;
   list_result_type               due_results [$];
   int                            fails;
   int                            checked;
   int                            fulls;

   function automatic int find_first(logic [ENTRY_ID_W-1:0] h);
      for (int i = 0; i < held_n; i++)
         if (held_id[i] == h)
            return i;
      return -1;
   endfunction

   function automatic void drop_at(int p);
      for (int i = p; i + 1 < held_n; i++) begin
         held_id[i]  = held_id[i+1];
         held_key[i] = held_key[i+1];
      end
      held_n--;
   endfunction

   // New entry goes in front of the first entry whose key is greater or equal.
   function automatic int insert_sorted(logic [ENTRY_ID_W-1:0] h,
                                        logic signed [DEPTH_KEY_W-1:0] k);
      int p;
      p = 0;
      while (p < held_n && k > held_key[p])
         p++;
      for (int i = held_n; i > p; i--) begin
         held_id[i]  = held_id[i-1];
         held_key[i] = held_key[i-1];
      end
      held_id[p]  = h;
      held_key[p] = k;
      held_n++;
      return p;
   endfunction

   function automatic list_result_type predict_result(dsel_req_type op,
                                                   logic [ENTRY_ID_W-1:0] h,
                                                   logic signed [DEPTH_KEY_W-1:0] k,
                                                   logic [SLOT_INDEX_W-1:0] slot);
      list_result_type r;
      int           p;
      logic         misplaced;
      r = '0;
      r.status = STAT_OK;
      case (op)
         REQ_ADD: begin
            if (held_n >= DEF_LIST_DEPTH)
               r.status = STAT_FULL;
            else
               r.slot_now = SLOT_NOW_W'(insert_sorted(h, k));
         end
         REQ_MOVE: begin
            p = find_first(h);
            if (p < 0) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               // A key equal to a neighbor still counts as in order.
               misplaced = 1'b0;
               if (p != 0)
                  if (k < held_key[p-1])
                     misplaced = 1'b1;
               if (p + 1 < held_n)
                  if (k > held_key[p+1])
                     misplaced = 1'b1;
               if (misplaced) begin
                  drop_at(p);
                  r.slot_now = SLOT_NOW_W'(insert_sorted(h, k));
               end else begin
                  held_key[p] = k;
                  r.slot_now  = SLOT_NOW_W'(p);
               end
            end
         end
         REQ_REMOVE: begin
            p = find_first(h);
            if (p < 0) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               drop_at(p);
               r.slot_now = SLOT_NOW_W'(p);
            end
         end
         default: begin
            if (slot < held_n) begin
               r.read_id  = held_id[slot];
               r.slot_now = slot;
            end else begin
               r.status = STAT_BAD_SLOT;
            end
         end
      endcase
      r.entry_count = ENTRY_COUNT_W'(held_n);
      return r;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         fails++;
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         held_n = 0;
         due_results.delete();
         fails   = 0;
         checked = 0;
         fulls   = 0;
      end else begin
         // A result leaves only after its item has been taken, so the
         // result side is handled first within one edge.
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               fails++;
               $display("%0t: expected no result, got status %0d data 0x%0h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = due_results.pop_front();
               checked++;
               check_field("status", want.status, rsp_tuser);
               check_field("slot_now", want.slot_now, rsp_tdata[0 +: SLOT_NOW_W]);
               check_field("read_id", want.read_id, rsp_tdata[SLOT_NOW_W +: READ_ID_W]);
               check_field("entry_count", want.entry_count,
                           rsp_tdata[SLOT_NOW_W+READ_ID_W +: ENTRY_COUNT_W]);
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_result(dsel_req_type'(req_tuser),
                                  req_tdata[0 +: ENTRY_ID_W],
                                  req_tdata[ENTRY_ID_W +: DEPTH_KEY_W],
                                  req_tdata[ENTRY_ID_W+DEPTH_KEY_W +: SLOT_INDEX_W]);
            if (want.status == STAT_FULL)
               fulls++;
            due_results.insert(due_results.size(), want);
         end
      end
      fail_count      <= fails;
      results_checked <= checked;
      full_rejects    <= fulls;
      n_due           <= due_results.size();
   end

endmodule

// ===== tb/tb_depth_sorted_entry_list.sv =====
`timescale 1ns / 100ps
// Testbench top for the depth-sorted entry list: clock, reset, stimulus and verdict.
module tb_depth_sorted_entry_list;
   import dsel_pkg::*;

   // A move may walk the whole list twice and both sides may idle between
   // items, so this leaves a wide margin over the slowest legal run of the
   // planned item count.
   localparam int CYCLE_LIMIT  = 2_500_000;
   localparam int RANDOM_ITEMS = 1900;
   localparam int PHASE_LEN    = 120;
   localparam int LONG_HOLD    = 600;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // entry_id [15:0], depth_key [31:16], slot_index [37:32], zero fill above
   logic [REQ_TDATA_W-1:0]   req_tdata  = '0;
   // req_type [1:0]
   logic [REQ_TYPE_W-1:0]    req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // slot_now [5:0], read_id [21:6], entry_count [28:22], zero fill above
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   // status [1:0]
   logic [STATUS_W-1:0]      rsp_tuser;

   int   fail_count;
   int   results_checked;
   int   full_rejects;
   int   n_due;
   int   cycle_count;
   int   sent_by_op [4];
   bit   send_calm;
   bit   take_calm;

   // Handles that were added, so that moves and removes mostly hit a
   // present entry. This is only a stimulus aid; stale handles just miss.
   logic [ENTRY_ID_W-1:0] handle_pool [$];

   always #4 clock = ~clock;

   depth_sorted_entry_list i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   dsel_result_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .fail_count      (fail_count),
      .results_checked (results_checked),
      .full_rejects    (full_rejects),
      .n_due           (n_due)
   );

   // Idle cycles before the next item on either side. A calm stretch
   // runs back to back so that full-rate streaming is covered as well.
   function automatic int pick_gap(bit calm);
      return calm ? 0 : int'($urandom_range(0, 14));
   endfunction

   // Offers one item and returns at the edge where it is accepted. The valid
   // is lowered only when a gap follows, so it never toggles within a step.
   task automatic issue(dsel_req_type op, logic [ENTRY_ID_W-1:0] h,
                        logic [DEPTH_KEY_W-1:0] k, logic [SLOT_INDEX_W-1:0] slot);
      int gap;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-REQ_FIELDS_W){1'b0}}, slot, k, h};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_by_op[op]++;
      if ($urandom_range(0, 39) == 0)
         send_calm = !send_calm;
   endtask

   // Result side. It idles a random number of cycles before each item and,
   // at two points in the run, holds off for a long stretch while the
   // sender keeps offering, so that the block backs up and stalls its input.
   initial begin
      int gap;
      int taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = pick_gap(take_calm);
         if (taken == 150 || taken == 900)
            gap = LONG_HOLD;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         if ($urandom_range(0, 39) == 0)
            take_calm = !take_calm;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("depth_sorted_entry_list: mismatch");
      $finish;
   end

   initial begin
      dsel_req_type             op;
      logic [ENTRY_ID_W-1:0]    h;
      logic [DEPTH_KEY_W-1:0]   k;
      logic [SLOT_INDEX_W-1:0]  slot;
      int                       roll;
      int                       pick;
      int                       phase_kind;
      int                       add_cut;
      int                       move_cut;
      int                       remove_cut;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. On an empty list, reads, moves and removes must all
      // report their error without touching the count.
      issue(REQ_READ,   16'h0000, 16'h0000, 6'd0);
      issue(REQ_REMOVE, 16'hBEEF, 16'h0000, 6'd0);
      issue(REQ_MOVE,   16'hBEEF, 16'h0000, 6'd0);
      // Key extremes, a middle key and a duplicate handle with an equal key,
      // which must land in front of the existing one.
      issue(REQ_ADD,    16'hFFFF, 16'h7FFF, 6'd63);
      issue(REQ_ADD,    16'h0000, 16'h8000, 6'd0);
      issue(REQ_ADD,    16'h1234, 16'h0000, 6'd0);
      issue(REQ_ADD,    16'h1234, 16'h0000, 6'd0);
      issue(REQ_ADD,    16'hA5A5, 16'hFFF0, 6'd0);
      // Moves that stay in place: same key at the head, a key equal to the
      // left neighbor and a key equal to the right neighbor.
      issue(REQ_MOVE,   16'h0000, 16'h8000, 6'd0);
      issue(REQ_MOVE,   16'h1234, 16'hFFF0, 6'd0);
      issue(REQ_MOVE,   16'h1234, 16'h0000, 6'd0);
      // Moves that break the order and must reinsert: toward the far end, in front
      // of an entry with an equal key, and to the very front.
      issue(REQ_MOVE,   16'h0000, 16'h7FFF, 6'd0);
      issue(REQ_MOVE,   16'hFFFF, 16'h8000, 6'd0);
      // Reads inside the list, at its last slot and beyond its count.
      issue(REQ_READ,   16'h0000, 16'h0000, 6'd0);
      issue(REQ_READ,   16'h0000, 16'h0000, 6'd4);
      issue(REQ_READ,   16'h0000, 16'h0000, 6'd5);
      issue(REQ_READ,   16'hFFFF, 16'hFFFF, 6'd63);
      // Removes of the first of two duplicates, of the head and of a
      // handle that is not present.
      issue(REQ_REMOVE, 16'h1234, 16'h0000, 6'd0);
      issue(REQ_REMOVE, 16'hFFFF, 16'h0000, 6'd0);
      issue(REQ_REMOVE, 16'h5A5A, 16'h0000, 6'd0);

      // Random part in phases: the list grows until it is full and adds are
      // refused, churns with moves, then drains toward empty, and so on.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         phase_kind = (n / PHASE_LEN) % 4;
         case (phase_kind)
            0: begin
               add_cut = 70; move_cut = 80; remove_cut = 88;
            end
            2: begin
               add_cut = 10; move_cut = 25; remove_cut = 85;
            end
            default: begin
               add_cut = 25; move_cut = 60; remove_cut = 80;
            end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < add_cut)
            op = REQ_ADD;
         else if (roll < move_cut)
            op = REQ_MOVE;
         else if (roll < remove_cut)
            op = REQ_REMOVE;
         else
            op = REQ_READ;

         // Small handle values give plenty of duplicates; full-width ones
         // exercise every bit of the field.
         if (op == REQ_ADD) begin
            if ($urandom_range(0, 9) < 4)
               h = ENTRY_ID_W'($urandom);
            else
               h = ENTRY_ID_W'($urandom_range(0, 63));
            handle_pool.insert(handle_pool.size(), h);
         end else if (handle_pool.size() > 0 && $urandom_range(0, 99) < 85) begin
            pick = $urandom_range(0, handle_pool.size() - 1);
            h = handle_pool[pick];
            if (op == REQ_REMOVE)
               handle_pool.delete(pick);
         end else begin
            h = ENTRY_ID_W'($urandom);
         end

         // Keys near zero collide often, which covers equal-key inserts and
         // moves that match a neighbor.
         case ($urandom_range(0, 3))
            0: k = DEPTH_KEY_W'($urandom_range(0, 6)) - DEPTH_KEY_W'(3);
            1: k = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: k = DEPTH_KEY_W'($urandom);
         endcase

         if ($urandom_range(0, 1))
            slot = SLOT_INDEX_W'($urandom_range(0, 15));
         else
            slot = SLOT_INDEX_W'($urandom);

         issue(op, h, k, slot);
      end
      req_tvalid <= 1'b0;

      // The checker's pending count is registered, so step first.
      @(posedge clock);
      while (n_due != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("Sent %0d adds, %0d moves, %0d removes and %0d slot reads; %0d results checked.",
               sent_by_op[REQ_ADD], sent_by_op[REQ_MOVE], sent_by_op[REQ_REMOVE],
               sent_by_op[REQ_READ], results_checked);
      $display("Adds refused on a full list: %0d; output held off twice for %0d cycles.",
               full_rejects, LONG_HOLD);
      if (fail_count == 0 && n_due == 0)
         $display("depth_sorted_entry_list: match");
      else
         $display("depth_sorted_entry_list: mismatch");
      $finish;
   end

endmodule

// ===== depth_sorted_entry_list.f =====
hw/rtl/dsel_pkg.sv
hw/rtl/depth_sorted_entry_list.sv
tb/dsel_result_checker.sv
tb/tb_depth_sorted_entry_list.sv
